[hdl/ttc_pkg.sv]
package ttc_pkg;

  localparam int TIMER_SLOTS = 16;
  localparam int SLOT_W = $clog2(TIMER_SLOTS);
  localparam int CNT_W = $clog2(TIMER_SLOTS + 1);
  localparam int MAX_RESULTS = 16;
  localparam int FIRE_W = $clog2(MAX_RESULTS + 1);

  typedef enum logic [2:0] {
    KIND_ADD = 3'd0,
    KIND_CANCEL_OWNER = 3'd1,
    KIND_CANCEL_OBJECT = 3'd2,
    KIND_QUERY = 3'd3,
    KIND_TICK = 3'd4,
    KIND_CLEAR = 3'd5,
    KIND_COUNT = 3'd6,
    KIND_NONE = 3'd7
  } kind_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] owner_id;
    logic        script_owned;
    logic [15:0] object_id;
    logic [7:0]  callback_tag;
    logic [30:0] delay;
    logic [30:0] interval;
    logic        repeating;
    logic [30:0] tick_time;
  } req_t;

  typedef struct packed {
    logic        status;
    logic        fired;
    logic [15:0] fired_owner;
    logic        fired_script_owned;
    logic [15:0] fired_object;
    logic [7:0]  fired_tag;
    logic        is_invoking;
    logic [4:0]  active_count;
    logic        last;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT,
    ST_PACK,
    ST_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic scan_step;
    logic pack_start;
    logic pack_step;
    logic emit_done;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_tick;
    logic scan_end;
    logic fire_now;
    logic pack_end;
  } sts_t;

endpackage

[hdl/ttc_if.sv]
interface ttc_req_if;
  import ttc_pkg::*;
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface ttc_rsp_if;
  import ttc_pkg::*;
  logic valid;
  logic ready;
  rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[hdl/ttc_ctrl.sv]
module ttc_ctrl
  import ttc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic out_busy,
  output logic out_push,
  output logic out_last,
  output cmd_t cmd,
  input  sts_t sts
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_SCAN;
      ST_SCAN: begin
        if (sts.fire_now) state_next = ST_EMIT;
        else if (sts.scan_end) state_next = sts.is_tick ? ST_PACK : ST_DONE;
      end
      ST_EMIT: if (!out_busy) state_next = ST_SCAN;
      ST_PACK: if (sts.pack_end) state_next = ST_DONE;
      ST_DONE: if (!out_busy) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd = '0;
    out_push = 1'b0;
    out_last = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_SCAN: begin
        cmd.scan_step = !sts.fire_now && !sts.scan_end;
        cmd.pack_start = !sts.fire_now && sts.scan_end && sts.is_tick;
      end
      ST_EMIT: begin
        // held fired beat goes out; the newest one waits for the done state
        out_push = !out_busy;
        cmd.emit_done = !out_busy;
      end
      ST_PACK: cmd.pack_step = 1'b1;
      ST_DONE: begin
        out_push = !out_busy;
        out_last = 1'b1;
      end
      default: ;
    endcase
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == ST_IDLE) else $error("ready outside idle");
  a_push_ok: assert property (@(posedge clk) disable iff (rst)
    out_push |-> !out_busy) else $error("push into busy output");
  a_load_scan: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == ST_SCAN) else $error("load did not start scan");

endmodule

[hdl/ttc_dp.sv]
module ttc_dp
  import ttc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  req_t req,
  input  cmd_t cmd,
  output sts_t sts,
  input  logic out_push,
  input  logic out_last,
  output rsp_t beat
);

  logic [TIMER_SLOTS-1:0] used, active;
  logic [16:0] owner [TIMER_SLOTS];
  logic [15:0] object [TIMER_SLOTS];
  logic [7:0]  tag [TIMER_SLOTS];
  logic [31:0] remaining [TIMER_SLOTS];
  logic [31:0] interval [TIMER_SLOTS];
  logic [TIMER_SLOTS-1:0] rpt;

  req_t r;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] wr;
  logic [CNT_W-1:0] cnt;
  logic [FIRE_W-1:0] nfired;
  logic status, hit, pending;
  logic [16:0] fo;
  logic [15:0] fobj;
  logic [7:0] ftag;

  logic [SLOT_W-1:0] i;
  logic [16:0] okey;
  logic live, fires, place;
  logic [31:0] dt, deficit;

  assign i = idx[SLOT_W-1:0];
  assign okey = {r.script_owned, r.owner_id};
  assign live = used[i] && active[i];
  assign dt = {1'b0, r.tick_time};
  assign fires = live && (dt >= remaining[i]);
  assign deficit = dt - remaining[i];
  // used slots form a prefix, so the first free slot sits at the used count
  assign place = (r.kind == KIND_ADD) && !used[i] && (idx == cnt);

  assign sts.is_tick = (r.kind == KIND_TICK);
  assign sts.scan_end = (idx == CNT_W'(TIMER_SLOTS));
  // a new firing while one is held pushes the held one out first
  assign sts.fire_now = sts.is_tick && pending && fires && !sts.scan_end &&
                        (nfired != FIRE_W'(MAX_RESULTS));
  assign sts.pack_end = sts.scan_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      active <= '0;
      idx <= '0;
      pending <= 1'b0;
    end else if (cmd.load) begin
      r <= req;
      idx <= '0;
      wr <= '0;
      cnt <= '0;
      nfired <= '0;
      status <= 1'b0;
      hit <= 1'b0;
      pending <= 1'b0;
      if (req.kind == KIND_CLEAR) begin
        used <= '0;
        active <= '0;
      end
    end else if (cmd.emit_done) begin
      pending <= 1'b0;
    end else if (cmd.scan_step) begin
      idx <= place ? CNT_W'(TIMER_SLOTS) : idx + 1'b1;
      unique case (r.kind)
        KIND_ADD: begin
          if (place) begin
            used[i] <= 1'b1;
            active[i] <= 1'b1;
            owner[i] <= okey;
            object[i] <= r.object_id;
            tag[i] <= r.callback_tag;
            remaining[i] <= {1'b0, r.delay};
            interval[i] <= r.repeating ? {1'b0, r.interval} : '0;
            rpt[i] <= r.repeating;
          end else if (used[i]) begin
            cnt <= cnt + 1'b1;
            if (idx == CNT_W'(TIMER_SLOTS - 1)) status <= 1'b1;
          end
        end
        KIND_CANCEL_OWNER: if (used[i] && owner[i] == okey) active[i] <= 1'b0;
        KIND_CANCEL_OBJECT: if (used[i] && object[i] == r.object_id) active[i] <= 1'b0;
        KIND_QUERY: if (live && owner[i] == okey) hit <= 1'b1;
        KIND_COUNT: if (live) cnt <= cnt + 1'b1;
        KIND_TICK: begin
          if (fires) begin
            if (rpt[i]) remaining[i] <= (interval[i] > deficit) ? interval[i] - deficit : '0;
            else active[i] <= 1'b0;
            if (nfired != FIRE_W'(MAX_RESULTS)) begin
              nfired <= nfired + 1'b1;
              pending <= 1'b1;
              fo <= owner[i];
              fobj <= object[i];
              ftag <= tag[i];
            end
          end else if (live) begin
            remaining[i] <= remaining[i] - dt;
          end
        end
        default: ;
      endcase
    end else if (cmd.pack_start) begin
      idx <= '0;
    end else if (cmd.pack_step) begin
      // compaction sweep: one source slot per cycle, write pointer trails
      if (sts.scan_end) begin
        idx <= CNT_W'(TIMER_SLOTS);
      end else begin
        idx <= idx + 1'b1;
        if (live) begin
          owner[wr[SLOT_W-1:0]] <= owner[i];
          object[wr[SLOT_W-1:0]] <= object[i];
          tag[wr[SLOT_W-1:0]] <= tag[i];
          remaining[wr[SLOT_W-1:0]] <= remaining[i];
          interval[wr[SLOT_W-1:0]] <= interval[i];
          rpt[wr[SLOT_W-1:0]] <= rpt[i];
          used[wr[SLOT_W-1:0]] <= 1'b1;
          active[wr[SLOT_W-1:0]] <= 1'b1;
          if (wr != idx) begin
            used[i] <= 1'b0;
            active[i] <= 1'b0;
          end
          wr <= wr + 1'b1;
        end else begin
          used[i] <= 1'b0;
          active[i] <= 1'b0;
        end
      end
    end
  end

  // the newest firing stays held so the final fired beat can carry last
  always_comb begin
    beat = '0;
    beat.last = out_last;
    if (pending) begin
      beat.fired = 1'b1;
      beat.fired_owner = fo[15:0];
      beat.fired_script_owned = fo[16];
      beat.fired_object = fobj;
      beat.fired_tag = ftag;
    end
    if (out_last) begin
      beat.status = (r.kind == KIND_ADD) && status;
      beat.is_invoking = (r.kind == KIND_QUERY) && hit;
      beat.active_count = (r.kind == KIND_COUNT) ? 5'(cnt) : '0;
    end
  end

  a_push_src: assert property (@(posedge clk) disable iff (rst)
    (out_push && !out_last) |-> pending) else $error("fired beat without pending");
  a_wr_le: assert property (@(posedge clk) disable iff (rst)
    cmd.pack_step |-> wr <= idx) else $error("write pointer ahead");
  a_pack_zero: assert property (@(posedge clk) disable iff (rst)
    cmd.pack_start |=> idx == '0) else $error("pack sweep not started at zero");

endmodule

[hdl/timer_table_with_cancel_top.sv]
// Timer table of TIMER_SLOTS entries. Every request scans the table one slot per cycle,
// except that a tick's scan waits while a held firing beat goes out (an add that finds a
// free slot stops at that slot). A tick then runs a compaction sweep that moves live
// entries to the front. A tick sends one beat per firing timer with last on the final
// one, or a single beat with fired 0 when nothing fires; other requests send one beat.
// Every beat waits while the output register still holds an unaccepted beat.
module timer_table_with_cancel_top
  import ttc_pkg::*;
(
  input logic clk,
  input logic rst,
  ttc_req_if.sink in,
  ttc_rsp_if.source out
);

  cmd_t cmd;
  sts_t sts;
  logic push, last_b;
  rsp_t beat;

  ttc_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(in.valid), .in_ready(in.ready),
    .out_busy(out.valid && !out.ready),
    .out_push(push), .out_last(last_b),
    .cmd, .sts
  );

  ttc_dp u_dp (
    .clk, .rst, .req(in.payload), .cmd, .sts,
    .out_push(push), .out_last(last_b), .beat
  );

  always_ff @(posedge clk) begin
    if (rst) out.valid <= 1'b0;
    else if (push) out.valid <= 1'b1;
    else if (out.ready) out.valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (push) out.payload <= beat;
  end

endmodule
